[hdl/fm_pll_demodulator_assert.svh]
// Assertion macros for the FM PLL demodulator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef FM_PLL_DEMODULATOR_ASSERT_SVH
`define FM_PLL_DEMODULATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Check an implication (or sequence property) on every clock edge out of reset
`define FPD_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds
`define FPD_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define FPD_ASSERT_IMPL(label, clk, rst, prop, msg)
`define FPD_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

[hdl/fpd_pkg.sv]
// Shared types, constants and the CORDIC arctangent table of the FM PLL demodulator.
// No dependencies; used by every module of the block.
package fpd_pkg;

   // Default parameter values
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int PHASE_BITS_DEF    = 32;
   localparam int ATAN_DEPTH        = 24;

   // Field and datapath widths
   localparam int STAGE_W    = 5;
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int STEP_W     = 32;
   localparam int DC_W       = 56;
   localparam int DC_FRAC    = 24;
   localparam int XY_W       = 34;
   localparam int Z_W        = 34;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_INCR_LOW   = 3'd2,
      CSR_INCR_HIGH  = 3'd3,
      CSR_AUDIO_GAIN = 3'd4,
      CSR_DC_COEFF   = 3'd5
   } csr_idx_type;

   // Register reset values
   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd21889;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd7313;
   localparam logic [STEP_W-1:0] INCR_LOW_RST   = 32'h8666_6666;
   localparam logic [STEP_W-1:0] INCR_HIGH_RST  = 32'h7999_999A;
   localparam logic [GAIN_W-1:0] AUDIO_GAIN_RST = 16'd256;
   localparam logic [GAIN_W-1:0] DC_COEFF_RST   = 16'd1678;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [GAIN_W-1:0]        prop_gain;
      logic [GAIN_W-1:0]        integ_gain;
      logic signed [STEP_W-1:0] incr_low_limit;
      logic signed [STEP_W-1:0] incr_high_limit;
      logic [GAIN_W-1:0]        audio_gain;
      logic [GAIN_W-1:0]        dc_coeff;
   } cfg_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic               load;
      logic               rot;
      logic               vec_init;
      logic               vec;
      logic               mult;
      logic               step;
      logic               nco;
      logic               dc;
      logic               aud;
      logic               out_load;
      logic [STAGE_W-1:0] stage;
   } cmd_type;

   // Arctangent of 2^-i in 2^-32 turn units
   function automatic logic [31:0] atan_turn(input logic [STAGE_W-1:0] idx);
      logic [31:0] val;
      unique case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933406;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335087;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41722;
         5'd15:   val = 32'd20861;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2608;
         5'd19:   val = 32'd1304;
         5'd20:   val = 32'd652;
         5'd21:   val = 32'd326;
         5'd22:   val = 32'd163;
         5'd23:   val = 32'd81;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

[hdl/fm_pll_demodulator.sv]
// FM PLL demodulator: sample in, loop-tracked phase step out as audio.
// Top level; depends on fpd_pkg, fpd_csr, fpd_ctrl and fpd_dpath.
//
// Usage:
//  - req channel carries one complex baseband sample per transfer; tdata holds in_re
//    (bits 15:0) and in_im (bits 31:16), tlast marks the last sample of a block.
//  - rsp channel returns exactly one audio sample per input with the same tlast.
//  - csr port writes one loop register per cycle; write only while the block is idle.
//  - Each sample passes CORDIC_STAGES rotation steps and CORDIC_STAGES vectoring steps
//    through one shared CORDIC unit, with one setup step between them, then six
//    loop-filter and output steps. The block takes no new sample until the previous
//    result is loaded into the output register. Stage counts above 24 run as 24.
//  - A finished result sits in the output register, so the next sample is accepted
//    while it waits; if it is still not taken when the following result is ready, the
//    block holds that result and stops accepting input.
//  - Reset (synchronous) clears NCO phase, phase step and DC estimate, restores the
//    register defaults and empties the output register.
module fm_pll_demodulator #(
   parameter int CORDIC_STAGES = fpd_pkg::CORDIC_STAGES_DEF,
   parameter int PHASE_BITS    = fpd_pkg::PHASE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: in_re [15:0], in_im [31:16]
   input  logic [31:0]                     req_tdata,
   input  logic                            req_tlast,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rsp_tdata: audio_out [15:0]
   output logic [15:0]                     rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_wr_en,
   input  logic [fpd_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  logic [fpd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   fpd_pkg::cfg_type                       cfg;
   fpd_pkg::cmd_type                       cmd;
   logic signed [fpd_pkg::SAMPLE_W-1:0]    audio;

   fpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fpd_ctrl #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   fpd_dpath #(
      .PHASE_BITS (PHASE_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .req_in_re          (req_tdata[15:0]),
      .req_in_im          (req_tdata[31:16]),
      .req_block_last     (req_tlast),
      .rsp_audio_out      (audio),
      .rsp_block_last_out (rsp_tlast)
   );

   assign rsp_tdata = audio;

endmodule

[hdl/fpd_csr.sv]
// Configuration register file of the FM PLL demodulator.
// Depends on fpd_pkg for register indexes, reset values and cfg_type.
module fpd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [fpd_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [fpd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output fpd_pkg::cfg_type                 cfg
);

   fpd_pkg::cfg_type cfg_ff, cfg_in;

   // Decode the write and update the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            fpd_pkg::CSR_PROP_GAIN:  cfg_in.prop_gain       = csr_wdata[fpd_pkg::GAIN_W-1:0];
            fpd_pkg::CSR_INTEG_GAIN: cfg_in.integ_gain      = csr_wdata[fpd_pkg::GAIN_W-1:0];
            fpd_pkg::CSR_INCR_LOW:   cfg_in.incr_low_limit  = csr_wdata[fpd_pkg::STEP_W-1:0];
            fpd_pkg::CSR_INCR_HIGH:  cfg_in.incr_high_limit = csr_wdata[fpd_pkg::STEP_W-1:0];
            fpd_pkg::CSR_AUDIO_GAIN: cfg_in.audio_gain      = csr_wdata[fpd_pkg::GAIN_W-1:0];
            fpd_pkg::CSR_DC_COEFF:   cfg_in.dc_coeff        = csr_wdata[fpd_pkg::GAIN_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain       <= fpd_pkg::PROP_GAIN_RST;
         cfg_ff.integ_gain      <= fpd_pkg::INTEG_GAIN_RST;
         cfg_ff.incr_low_limit  <= fpd_pkg::INCR_LOW_RST;
         cfg_ff.incr_high_limit <= fpd_pkg::INCR_HIGH_RST;
         cfg_ff.audio_gain      <= fpd_pkg::AUDIO_GAIN_RST;
         cfg_ff.dc_coeff        <= fpd_pkg::DC_COEFF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/fpd_ctrl.sv]
// Sequencing state machine of the FM PLL demodulator: handshakes and CORDIC stage count.
// Depends on fpd_pkg for cmd_type and STAGE_W, and on the assertion macro header.
`include "fm_pll_demodulator_assert.svh"

module fpd_ctrl #(
   parameter int CORDIC_STAGES = fpd_pkg::CORDIC_STAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output fpd_pkg::cmd_type  cmd
);

   localparam int N_EFF = (CORDIC_STAGES < fpd_pkg::ATAN_DEPTH) ?
                          CORDIC_STAGES : fpd_pkg::ATAN_DEPTH;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_ROT   = 10'b00_0000_0010,
      S_VINIT = 10'b00_0000_0100,
      S_VEC   = 10'b00_0000_1000,
      S_MULT  = 10'b00_0001_0000,
      S_STEP  = 10'b00_0010_0000,
      S_NCO   = 10'b00_0100_0000,
      S_DC    = 10'b00_1000_0000,
      S_AUD   = 10'b01_0000_0000,
      S_OUT   = 10'b10_0000_0000
   } state_type;

   state_type                     state_ff, state_in;
   logic [fpd_pkg::STAGE_W-1:0]   stage_ff, stage_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          accept;
   logic                          stage_last;
   logic                          out_load;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign stage_last = (stage_ff == fpd_pkg::STAGE_W'(N_EFF - 1));
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   // Advance through the per-sample steps
   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      unique case (state_ff)
         S_IDLE: begin
            stage_in = '0;
            if (accept) state_in = S_ROT;
         end
         S_ROT: begin
            if (stage_last) begin
               state_in = S_VINIT;
               stage_in = '0;
            end else begin
               stage_in = stage_ff + 1'b1;
            end
         end
         S_VINIT: begin
            stage_in = '0;
            state_in = S_VEC;
         end
         S_VEC: begin
            if (stage_last) begin
               state_in = S_MULT;
               stage_in = '0;
            end else begin
               stage_in = stage_ff + 1'b1;
            end
         end
         S_MULT:  state_in = S_STEP;
         S_STEP:  state_in = S_NCO;
         S_NCO:   state_in = S_DC;
         S_DC:    state_in = S_AUD;
         S_AUD:   state_in = S_OUT;
         S_OUT: begin
            if (out_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the result valid until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // Drive the datapath commands
   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.rot      = (state_ff == S_ROT);
      cmd.vec_init = (state_ff == S_VINIT);
      cmd.vec      = (state_ff == S_VEC);
      cmd.mult     = (state_ff == S_MULT);
      cmd.step     = (state_ff == S_STEP);
      cmd.nco      = (state_ff == S_NCO);
      cmd.dc       = (state_ff == S_DC);
      cmd.aud      = (state_ff == S_AUD);
      cmd.out_load = out_load;
      cmd.stage    = stage_ff;
   end

   `FPD_ASSERT_IMPL(a_accept_starts_rot, clock, reset, accept |=> (state_ff == S_ROT), "accepted sample did not start rotation")
   `FPD_ASSERT_NEVER(a_no_result_overwrite, clock, reset, out_load && rsp_valid_ff && !rsp_tready, "pending result overwritten")
   `FPD_ASSERT_IMPL(a_stage_in_range, clock, reset, (state_ff == S_ROT || state_ff == S_VEC) |-> (stage_ff < fpd_pkg::STAGE_W'(N_EFF)), "CORDIC stage index out of range")

endmodule

[hdl/fpd_dpath.sv]
// Datapath of the FM PLL demodulator: shared CORDIC, loop filter, NCO, DC tracker, output.
// Depends on fpd_pkg for types, widths and the arctangent table, and on the assertion header.
`include "fm_pll_demodulator_assert.svh"

module fpd_dpath #(
   parameter int PHASE_BITS = fpd_pkg::PHASE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fpd_pkg::cfg_type                     cfg,
   input  fpd_pkg::cmd_type                     cmd,
   input  logic signed [fpd_pkg::SAMPLE_W-1:0]  req_in_re,
   input  logic signed [fpd_pkg::SAMPLE_W-1:0]  req_in_im,
   input  logic                                 req_block_last,
   output logic signed [fpd_pkg::SAMPLE_W-1:0]  rsp_audio_out,
   output logic                                 rsp_block_last_out
);

   localparam int XW  = fpd_pkg::XY_W;
   localparam int ZW  = fpd_pkg::Z_W;
   localparam int SW  = fpd_pkg::STEP_W;
   localparam int DW  = fpd_pkg::DC_W;
   localparam int DF  = fpd_pkg::DC_FRAC;
   localparam int GW  = fpd_pkg::GAIN_W;
   localparam int SMW = fpd_pkg::SAMPLE_W;
   localparam int SHL = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
   localparam int SHR = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;

   // CORDIC registers
   logic signed [XW-1:0]     x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]     z_ff, z_in;
   logic                     zero_ff, zero_in;
   logic                     last_ff, last_in;

   // Loop state
   logic [PHASE_BITS-1:0]    nco_ff, nco_in;
   logic signed [SW-1:0]     step_ff, step_in;
   logic signed [DW-1:0]     dc_ff, dc_in;

   // Product registers
   logic signed [48:0]       prod_i_ff, prod_i_in, prod_p_ff, prod_p_in;
   logic signed [49:0]       prod_dc_ff, prod_dc_in;
   logic signed [50:0]       prod_a_ff, prod_a_in;

   // Output register
   logic signed [SMW-1:0]    audio_ff, audio_in;
   logic                     olast_ff, olast_in;

   // Combinational helpers
   logic [PHASE_BITS+31:0]   th_wide;
   logic [31:0]              th, th_rot;
   logic                     flip;
   logic signed [XW-1:0]     re_s, im_s;
   logic signed [XW-1:0]     xs, ys;
   logic signed [ZW-1:0]     atan_ext;
   logic                     up;
   logic signed [31:0]       err;
   logic signed [48:0]       gi_ext, gp_ext, err_ext;
   logic signed [48:0]       qi_full, qp_full;
   logic signed [33:0]       step_sum, lo_ext, hi_ext, clamp_lo, clamp_hi, delta;
   logic signed [63:0]       delta_ext, delta_sc;
   logic signed [31:0]       dc_int;
   logic signed [32:0]       diff;
   logic signed [49:0]       gd_ext, diff_ext;
   logic signed [56:0]       dc_sum;
   logic signed [33:0]       yv;
   logic signed [50:0]       ga_ext, yv_ext;
   logic signed [26:0]       a_full;

   // Top 32 bits of the NCO phase, zero-filled when the phase is narrower
   assign th_wide = {nco_ff, 32'd0};
   assign th      = th_wide[PHASE_BITS+31 -: 32];
   assign flip    = th[31] ^ th[30];
   assign th_rot  = flip ? {~th[31], th[30:0]} : th;

   assign re_s = {{(XW-SMW-14){req_in_re[SMW-1]}}, req_in_re, 14'd0};
   assign im_s = {{(XW-SMW-14){req_in_im[SMW-1]}}, req_in_im, 14'd0};

   // One CORDIC micro-rotation; direction from z in rotation, from y in vectoring
   assign xs       = x_ff >>> cmd.stage;
   assign ys       = y_ff >>> cmd.stage;
   assign atan_ext = {{(ZW-32){1'b0}}, fpd_pkg::atan_turn(cmd.stage)};
   assign up       = cmd.rot ? !z_ff[ZW-1] : y_ff[XW-1];

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      zero_in = zero_ff;
      last_in = last_ff;
      if (cmd.load) begin
         x_in    = flip ? -re_s : re_s;
         y_in    = flip ? -im_s : im_s;
         z_in    = {{(ZW-32){th_rot[31]}}, th_rot};
         last_in = req_block_last;
      end else if (cmd.rot || cmd.vec) begin
         if (up) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_ext;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_ext;
         end
      end else if (cmd.vec_init) begin
         zero_in = (x_ff == '0) && (y_ff == '0);
         if (x_ff[XW-1]) begin
            x_in = -x_ff;
            y_in = -y_ff;
            z_in = {{(ZW-32){1'b0}}, 32'h8000_0000};
         end else begin
            z_in = '0;
         end
      end
   end

   // Phase error is the negated vector angle, wrapped to one turn
   assign err     = zero_ff ? 32'sd0 : $signed(32'd0 - z_ff[31:0]);
   assign err_ext = {{17{err[31]}}, err};
   assign gi_ext  = {33'd0, cfg.integ_gain};
   assign gp_ext  = {33'd0, cfg.prop_gain};

   always_comb begin
      prod_i_in = prod_i_ff;
      prod_p_in = prod_p_ff;
      if (cmd.mult) begin
         prod_i_in = gi_ext * err_ext;
         prod_p_in = gp_ext * err_ext;
      end
   end

   // Integral path: add to the step, apply low then high limit
   assign qi_full  = prod_i_ff >>> 15;
   assign step_sum = {{2{step_ff[SW-1]}}, step_ff} + qi_full[33:0];
   assign lo_ext   = {{2{cfg.incr_low_limit[SW-1]}}, cfg.incr_low_limit};
   assign hi_ext   = {{2{cfg.incr_high_limit[SW-1]}}, cfg.incr_high_limit};
   assign clamp_lo = (step_sum < lo_ext) ? lo_ext : step_sum;
   assign clamp_hi = (clamp_lo > hi_ext) ? hi_ext : clamp_lo;

   always_comb begin
      step_in = step_ff;
      if (cmd.step) step_in = clamp_hi[SW-1:0];
   end

   // Proportional path on top of the step, scaled to the phase width
   assign qp_full   = prod_p_ff >>> 15;
   assign delta     = {{2{step_ff[SW-1]}}, step_ff} + qp_full[33:0];
   assign delta_ext = {{30{delta[33]}}, delta};
   assign delta_sc  = (delta_ext <<< SHL) >>> SHR;

   // DC tracker error times coefficient
   assign dc_int   = dc_ff[DW-1:DF];
   assign diff     = {step_ff[SW-1], step_ff} - {dc_int[31], dc_int};
   assign gd_ext   = {34'd0, cfg.dc_coeff};
   assign diff_ext = {{17{diff[32]}}, diff};

   always_comb begin
      nco_in     = nco_ff;
      prod_dc_in = prod_dc_ff;
      if (cmd.nco) begin
         nco_in     = nco_ff + delta_sc[PHASE_BITS-1:0];
         prod_dc_in = gd_ext * diff_ext;
      end
   end

   // Accumulate and saturate the DC estimate
   assign dc_sum = {dc_ff[DW-1], dc_ff} + {{7{prod_dc_ff[49]}}, prod_dc_ff};

   always_comb begin
      dc_in = dc_ff;
      if (cmd.dc) begin
         if (dc_sum[DW] != dc_sum[DW-1]) begin
            dc_in = dc_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
         end else begin
            dc_in = dc_sum[DW-1:0];
         end
      end
   end

   // Output scaling: twice the step minus twice the DC, times the gain
   assign yv     = {diff, 1'b0};
   assign ga_ext = {35'd0, cfg.audio_gain};
   assign yv_ext = {{17{yv[33]}}, yv};

   always_comb begin
      prod_a_in = prod_a_ff;
      if (cmd.aud) prod_a_in = ga_ext * yv_ext;
   end

   assign a_full = prod_a_ff[50:24];

   always_comb begin
      audio_in = audio_ff;
      olast_in = olast_ff;
      if (cmd.out_load) begin
         olast_in = last_ff;
         if (a_full > 27'sd32767) begin
            audio_in = 16'sh7FFF;
         end else if (a_full < -27'sd32768) begin
            audio_in = 16'sh8000;
         end else begin
            audio_in = a_full[SMW-1:0];
         end
      end
   end

   // Loop state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nco_ff  <= '0;
         step_ff <= '0;
         dc_ff   <= '0;
      end else begin
         nco_ff  <= nco_in;
         step_ff <= step_in;
         dc_ff   <= dc_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      zero_ff    <= zero_in;
      last_ff    <= last_in;
      prod_i_ff  <= prod_i_in;
      prod_p_ff  <= prod_p_in;
      prod_dc_ff <= prod_dc_in;
      prod_a_ff  <= prod_a_in;
      audio_ff   <= audio_in;
      olast_ff   <= olast_in;
   end

   assign rsp_audio_out      = audio_ff;
   assign rsp_block_last_out = olast_ff;

   `FPD_ASSERT_IMPL(a_step_within_limits, clock, reset, cmd.step |=> (($past(cfg.incr_low_limit) > $past(cfg.incr_high_limit)) || ((step_ff >= $past(cfg.incr_low_limit)) && (step_ff <= $past(cfg.incr_high_limit)))), "phase step outside limits")
   `FPD_ASSERT_IMPL(a_zero_vector_no_error, clock, reset, (cmd.mult && zero_ff) |=> ((prod_i_ff == '0) && (prod_p_ff == '0)), "zero sample produced a phase error")
   `FPD_ASSERT_IMPL(a_vec_start_right_half, clock, reset, cmd.vec_init |=> !x_ff[XW-1], "vectoring started with negative x")

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the FM PLL demodulator: streams complex baseband samples,
// predicts every audio sample in a scoreboard class and compares it on the rsp channel.
// Depends on fpd_pkg and the fm_pll_demodulator top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     STAGES       = 16;
   localparam int     LIMIT_CYCLES = 600000;
   localparam int     DIRECTED_N   = 20;
   localparam longint DC_MAX       = 64'sh007F_FFFF_FFFF_FFFF;

   // Arctangent of 2^-i in 2^-32 turn units
   localparam longint ATAN_TURNS [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   // Directed samples: zero, full-scale corners, axes, half turn, bit patterns
   localparam logic [15:0] DIR_RE [DIRECTED_N] = '{
      16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000,
      16'h7FFF, 16'h0001, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h8000, 16'h0000, 16'h7FFF,
      16'h8001, 16'h0000, 16'h4000, 16'hC000};
   localparam logic [15:0] DIR_IM [DIRECTED_N] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
      16'h8000, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0000, 16'h0000, 16'h0001,
      16'h0000, 16'h0001, 16'hC000, 16'h4000};

   typedef struct packed {
      logic [15:0] audio;
      logic        last;
   } audio_sample_type;

   // Loop predictor plus the queue of audio samples still owed by the block
   class demod_scoreboard;
      logic [15:0]        prop_gain, integ_gain, audio_gain, dc_coeff;
      logic signed [31:0] step_floor, step_ceiling;
      logic [31:0]        nco_phase;
      logic signed [31:0] loop_step;
      logic signed [55:0] dc_level;
      audio_sample_type   expected_audio[$];
      int                 received;
      int                 failures;

      function new();
         prop_gain    = 16'd21889;
         integ_gain   = 16'd7313;
         step_floor   = -32'sd2040109466;
         step_ceiling = 32'sd2040109466;
         audio_gain   = 16'd256;
         dc_coeff     = 16'd1678;
         nco_phase    = '0;
         loop_step    = '0;
         dc_level     = '0;
         received     = 0;
         failures     = 0;
      endfunction

      function void write_reg(fpd_pkg::csr_idx_type idx, logic [31:0] value);
         case (idx)
            fpd_pkg::CSR_PROP_GAIN:  prop_gain    = value[15:0];
            fpd_pkg::CSR_INTEG_GAIN: integ_gain   = value[15:0];
            fpd_pkg::CSR_INCR_LOW:   step_floor   = value;
            fpd_pkg::CSR_INCR_HIGH:  step_ceiling = value;
            fpd_pkg::CSR_AUDIO_GAIN: audio_gain   = value[15:0];
            fpd_pkg::CSR_DC_COEFF:   dc_coeff     = value[15:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_audio.size();
      endfunction

      // Advance the loop by one sample and queue the audio it yields
      function void note_sample(logic [15:0] re, logic [15:0] im, logic last);
         longint           x, y, z, nx, ny, err, step, dc, yv, level;
         logic [31:0]      angle;
         audio_sample_type item;
         x = longint'($signed(re)) * 16384;
         y = longint'($signed(im)) * 16384;
         angle = nco_phase;
         // fold the second and third quadrants by a half turn
         if (angle[31] != angle[30]) begin
            x = -x;
            y = -y;
            angle[31] = ~angle[31];
         end
         z = longint'($signed(angle));
         for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               ny = y + (x >>> i);
               z  = z - ATAN_TURNS[i];
            end else begin
               nx = x + (y >>> i);
               ny = y - (x >>> i);
               z  = z + ATAN_TURNS[i];
            end
            x = nx;
            y = ny;
         end
         // measure the angle of the rotated vector; a zero vector gives no error
         if (x == 0 && y == 0) begin
            err = 0;
         end else begin
            z = 0;
            if (x < 0) begin
               x = -x;
               y = -y;
               z = 64'sd2147483648;
            end
            for (int i = 0; i < STAGES; i++) begin
               if (y >= 0) begin
                  nx = x + (y >>> i);
                  ny = y - (x >>> i);
                  z  = z + ATAN_TURNS[i];
               end else begin
                  nx = x - (y >>> i);
                  ny = y + (x >>> i);
                  z  = z - ATAN_TURNS[i];
               end
               x = nx;
               y = ny;
            end
            angle = 32'd0 - z[31:0];
            err = longint'($signed(angle));
         end
         // integral path, low limit first so the high limit wins when crossed
         step = longint'(loop_step) + ((longint'(integ_gain) * err) >>> 15);
         if (step < longint'(step_floor))
            step = step_floor;
         if (step > longint'(step_ceiling))
            step = step_ceiling;
         loop_step = step[31:0];
         nco_phase = nco_phase + step[31:0] + 32'((longint'(prop_gain) * err) >>> 15);
         // one-pole DC tracker, saturated to 56 bits
         dc = longint'(dc_level) + longint'(dc_coeff) * (step - (longint'(dc_level) >>> 24));
         if (dc > DC_MAX)
            dc = DC_MAX;
         if (dc < -DC_MAX - 1)
            dc = -DC_MAX - 1;
         dc_level = dc[55:0];
         yv = 2 * step - 2 * (dc >>> 24);
         level = (yv * longint'(audio_gain)) >>> 24;
         if (level > 32767)
            level = 32767;
         if (level < -32768)
            level = -32768;
         item.audio = level[15:0];
         item.last  = last;
         expected_audio.push_back(item);
      endfunction

      function void check_audio(logic [15:0] audio, logic last);
         audio_sample_type want;
         received++;
         if (expected_audio.size() == 0) begin
            $error("audio sample %0d arrived with no sample pending", $signed(audio));
            failures++;
         end else begin
            want = expected_audio.pop_front();
            if (want.audio !== audio) begin
               $error("audio_out: expected %0d, actual %0d", $signed(want.audio),
                      $signed(audio));
               failures++;
            end
            if (want.last !== last) begin
               $error("block_last_out: expected %0b, actual %0b", want.last, last);
               failures++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic [31:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_wr_en  = 1'b0;
   logic [fpd_pkg::CSR_ADDR_W-1:0] csr_index = fpd_pkg::CSR_PROP_GAIN;
   logic [fpd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   demod_scoreboard model = new();
   int              burst_left = 0;
   int              cycle_count = 0;

   fm_pll_demodulator #(
      .CORDIC_STAGES (STAGES),
      .PHASE_BITS    (32)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watch both channels: predict on each input transfer, check on each result transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            model.note_sample(req_tdata[15:0], req_tdata[31:16], req_tlast);
         if (rsp_tvalid && rsp_tready)
            model.check_audio(rsp_tdata, rsp_tlast);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Offer one sample and hold it until transfer; bursts end in a random gap
   task automatic send_sample(input logic [15:0] re, input logic [15:0] im,
                              input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      req_tdata  <= {im, re};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait until every predicted sample has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (model.pending() != 0) @(posedge clock);
   endtask

   // Write all six loop registers, one per cycle; block must be idle
   task automatic write_settings(input logic [15:0] pg, input logic [15:0] ig,
                                 input logic [31:0] lo, input logic [31:0] hi,
                                 input logic [15:0] ag, input logic [15:0] dcc);
      fpd_pkg::csr_idx_type idx [6];
      logic [31:0]          val [6];
      idx = '{fpd_pkg::CSR_PROP_GAIN, fpd_pkg::CSR_INTEG_GAIN, fpd_pkg::CSR_INCR_LOW,
              fpd_pkg::CSR_INCR_HIGH, fpd_pkg::CSR_AUDIO_GAIN, fpd_pkg::CSR_DC_COEFF};
      val = '{{16'd0, pg}, {16'd0, ig}, lo, hi, {16'd0, ag}, {16'd0, dcc}};
      for (int k = 0; k < 6; k++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         model.write_reg(idx[k], val[k]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // Mostly FM-modulated carriers in blocks, with noise and corner-value runs between
   task automatic run_random(input int count);
      int  sent, kind, len, re_i, im_i;
      real ph, f0, dev, mph, mf, amp;
      logic [15:0] corners [5];
      corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            len = $urandom_range(20, 80);
            len = (len > count - sent) ? count - sent : len;
            ph  = $urandom_range(0, 6283) / 1000.0;
            f0  = ($urandom_range(0, 2000) - 1000.0) / 1250.0;
            dev = $urandom_range(0, 300) / 1000.0;
            mf  = $urandom_range(1, 100) / 1000.0;
            mph = 0.0;
            case ($urandom_range(0, 3))
               0:       amp = 32767.0;
               1:       amp = $urandom_range(1000, 32767);
               2:       amp = $urandom_range(1, 200);
               default: amp = 16000.0;
            endcase
            for (int k = 0; k < len; k++) begin
               ph   = ph + f0 + dev * $sin(mph);
               mph  = mph + mf;
               re_i = $rtoi(amp * $cos(ph));
               im_i = $rtoi(amp * $sin(ph));
               send_sample(re_i[15:0], im_i[15:0], k == len - 1);
            end
         end else if (kind <= 8) begin
            len = $urandom_range(1, 20);
            len = (len > count - sent) ? count - sent : len;
            for (int k = 0; k < len; k++)
               send_sample(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           1'($urandom_range(0, 1)));
         end else begin
            len = $urandom_range(1, 8);
            len = (len > count - sent) ? count - sent : len;
            for (int k = 0; k < len; k++)
               send_sample(corners[$urandom_range(0, 4)], corners[$urandom_range(0, 4)],
                           k == len - 1);
         end
         sent += len;
      end
   endtask

   // Result side: long ready stretches, random stalls, and one long hold-off
   initial begin : result_sink
      int mode, len;
      bit held;
      held = 1'b0;
      forever begin
         if (!held && model.received >= 300) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (500) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         len  = (mode <= 1) ? $urandom_range(10, 200) : $urandom_range(1, 40);
         repeat (len) begin
            case (mode)
               0, 1:    rsp_tready <= 1'b1;
               2:       rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= 1'b0;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [15:0] pg, ig, ag, dcc;
      logic [31:0] lo, hi, span;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed samples on the reset settings
      for (int k = 0; k < DIRECTED_N; k++)
         send_sample(DIR_RE[k], DIR_IM[k], k[0]);
      drain();

      // reset values written back explicitly
      write_settings(16'd21889, 16'd7313, 32'h8666_6666, 32'h7999_999A, 16'd256, 16'd1678);
      run_random(100);
      drain();

      // open loop, widest limits, full audio gain to force saturation
      write_settings(16'd0, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'd0);
      run_random(100);
      drain();

      // maximum gains, crossed limits, muted audio, fastest DC tracking
      write_settings(16'hFFFF, 16'hFFFF, 32'sd1000000, -32'sd1000000, 16'd0, 16'hFFFF);
      run_random(100);
      drain();

      // maximum gains with widest limits and loud output
      write_settings(16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd4096, 16'd1678);
      run_random(100);

      // random settings
      repeat (4) begin
         drain();
         pg  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(2000, 30000));
         ig  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(500, 12000));
         if ($urandom_range(0, 3) == 0) begin
            lo = $urandom;
            hi = $urandom;
         end else begin
            span = $urandom_range(100000000, 2147483647);
            lo = 32'd0 - span;
            hi = span;
         end
         ag  = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(64, 1024));
         dcc = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535)) : 16'd1678;
         write_settings(pg, ig, lo, hi, ag, dcc);
         run_random(100);
      end

      // settle, then look for stray results
      drain();
      repeat (100) @(posedge clock);
      if (model.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
